FILE: hw/rtl/ttb_pkg.sv
package ttb_pkg;

	// Sequencer state codes.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DET   = 4'd1;
	localparam logic [3:0] ST_NUM   = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_CROSS = 4'd4;
	localparam logic [3:0] ST_DOT   = 4'd5;
	localparam logic [3:0] ST_FLIP  = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	// Multiply unit operation codes.
	localparam logic [1:0] MOP_SET = 2'd0;
	localparam logic [1:0] MOP_ADD = 2'd1;
	localparam logic [1:0] MOP_SUB = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} mul_ctl_t;

endpackage

FILE: hw/rtl/triangle_tangent_bitangent.sv
// Per-triangle tangent and bitangent unit. Vertices arrive one word at a
// time; the first two words of a triangle are stored. The third word
// starts the computation: the determinant, six numerators, six divisions,
// the normal cross product and its dot product with the bitangent all run
// through one shared multiply-accumulate unit and one bit-serial divider.
// Each product passes through issue, a product register and accumulate.
// Each of the six quotients is shifted out of the divider one bit at a
// time, followed by a handshake. The orientation flip and the load of the
// output register follow; a zero determinant skips the divisions and the
// orientation test, sets degenerate and gives zero vectors. s_tready is low
// while a triangle is being computed. The result word waits in an output
// register, so new vertices are taken while it is held; a finished triangle
// then waits until the held word is taken.
module triangle_tangent_bitangent import ttb_pkg::*; #(
	parameter int COORD_WIDTH  = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (low bit up)
	input  logic [((5*COORD_WIDTH+3*NORMAL_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tangent_x/y/z, bitangent_x/y/z (low bit up)
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);
	localparam int CW   = COORD_WIDTH;
	localparam int NW   = NORMAL_WIDTH;
	localparam int CF   = CW / 2;
	localparam int NF   = NW - 2;
	localparam int OP_W = (CW + 2 > NW + 1) ? CW + 2 : NW + 1;
	localparam int ACC_W = 2 * OP_W + 4;
	localparam int N_W  = ACC_W + CF;
	localparam int XW   = CW + NW + 2;
	localparam int DW   = 2 * CW + NW + 6;
	localparam int OW   = ((6 * CW + 7) / 8) * 8;
	localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW-1:0] in_p [3];
	logic signed [CW-1:0] in_t [2];
	logic signed [NW-1:0] in_n [3];
	always_comb begin
		for (int k = 0; k < 3; k++) in_p[k] = s_tdata[k*CW +: CW];
		for (int k = 0; k < 2; k++) in_t[k] = s_tdata[(3+k)*CW +: CW];
		for (int k = 0; k < 3; k++) in_n[k] = s_tdata[5*CW + k*NW +: NW];
	end

	logic [1:0]           phase_q;
	logic [3:0]           st_q;
	logic signed [CW-1:0] p0_q [3];
	logic signed [CW-1:0] p1_q [3];
	logic signed [CW-1:0] t0_q [2];
	logic signed [CW-1:0] t1_q [2];
	logic signed [NW-1:0] n0_q [3];
	logic signed [CW:0]   e1_q [3];
	logic signed [CW:0]   e2_q [3];
	logic signed [CW:0]   d1_q [2];
	logic signed [CW:0]   d2_q [2];
	logic signed [ACC_W-1:0] det_q;
	logic signed [ACC_W-1:0] num_q [6];
	logic signed [CW-1:0] res_q [6];
	logic signed [XW-1:0] cr_q [3];
	logic signed [DW-1:0] dot_q;
	logic [2:0]           idx_q;
	logic                 wait_q;
	logic                 degen_q;
	logic                 vout_q;
	logic [OW-1:0]        odata_q;
	logic                 ouser_q;
	logic [OW-1:0]        opack;

	// Shared multiply-accumulate sequencing: step_q counts product terms.
	mul_ctl_t             mctl;
	logic signed [OP_W-1:0] ma, mb;
	logic signed [ACC_W-1:0] macc;
	logic                 mdone;
	logic [2:0]           step_q;
	logic [2:0]           idx_m3;

	assign idx_m3 = idx_q - 3'd3;

	ttb_mac #(.OP_W(OP_W), .ACC_W(ACC_W)) u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb),
		.acc(macc), .done(mdone)
	);

	logic               dstart;
	logic [N_W-1:0]     dnum;
	logic [ACC_W-1:0]   dden;
	logic [N_W-1:0]     dquo;
	logic               dbusy;

	ttb_div #(.N_W(N_W), .D_W(ACC_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.quo(dquo), .busy(dbusy)
	);

	logic signed [ACC_W-1:0] cur_num;
	logic                    qneg;
	logic [ACC_W-1:0]        nmag, dmag;
	assign cur_num = num_q[idx_q];
	assign qneg = cur_num[ACC_W-1] ^ det_q[ACC_W-1];
	assign nmag = cur_num[ACC_W-1] ? ACC_W'(-cur_num) : ACC_W'(cur_num);
	assign dmag = det_q[ACC_W-1] ? ACC_W'(-det_q) : ACC_W'(det_q);
	assign dnum = {nmag, {CF{1'b0}}};
	assign dden = dmag;
	assign dstart = (st_q == ST_DIV) && !wait_q;

	logic signed [CW-1:0] qsat;
	logic                 qneg_q;
	always_comb begin
		if (qneg) qsat = (dquo > N_W'(SMIN[CW-1:0])) ? SMIN : CW'(-$signed(dquo));
		else      qsat = (dquo > N_W'(SMAX)) ? SMAX : CW'(dquo);
		if (qneg_q) qsat = (dquo > N_W'({1'b1, {(CW-1){1'b0}}})) ? SMIN
			: CW'(-$signed({1'b0, dquo}));
	end

	// Operand selection for the shared unit.
	always_comb begin
		ma = '0;
		mb = '0;
		mctl.start = 1'b0;
		mctl.op = MOP_SET;
		case (st_q)
			ST_DET: begin
				mctl.start = !wait_q;
				if (step_q == 3'd0) begin
					ma = OP_W'(d1_q[0]); mb = OP_W'(d2_q[1]);
				end else begin
					ma = OP_W'(d2_q[0]); mb = OP_W'(d1_q[1]); mctl.op = MOP_SUB;
				end
			end
			ST_NUM: begin
				mctl.start = !wait_q;
				mctl.op = step_q[0] ? MOP_SUB : MOP_SET;
				if (idx_q < 3'd3) begin
					ma = step_q[0] ? OP_W'(e2_q[idx_q[1:0]]) : OP_W'(e1_q[idx_q[1:0]]);
					mb = step_q[0] ? OP_W'(d1_q[1]) : OP_W'(d2_q[1]);
				end else begin
					ma = step_q[0] ? OP_W'(e1_q[idx_m3[1:0]]) : OP_W'(e2_q[idx_m3[1:0]]);
					mb = step_q[0] ? OP_W'(d2_q[0]) : OP_W'(d1_q[0]);
				end
			end
			ST_CROSS: begin
				mctl.start = !wait_q;
				mctl.op = step_q[0] ? MOP_SUB : MOP_SET;
				case (idx_q)
					3'd0: begin
						ma = OP_W'(step_q[0] ? n0_q[2] : n0_q[1]);
						mb = OP_W'(step_q[0] ? res_q[1] : res_q[2]);
					end
					3'd1: begin
						ma = OP_W'(step_q[0] ? n0_q[0] : n0_q[2]);
						mb = OP_W'(step_q[0] ? res_q[2] : res_q[0]);
					end
					default: begin
						ma = OP_W'(step_q[0] ? n0_q[1] : n0_q[0]);
						mb = OP_W'(step_q[0] ? res_q[0] : res_q[1]);
					end
				endcase
			end
			ST_DOT: begin
				// Each floored cross term fits the operand width.
				mctl.start = !wait_q;
				mctl.op = (idx_q == 3'd0) ? MOP_SET : MOP_ADD;
				ma = OP_W'(cr_q[idx_q[1:0]]);
				mb = OP_W'(res_q[3'd3 + idx_q]);
			end
			default: begin
			end
		endcase
	end

	logic signed [XW-1:0] cr_sh;
	assign cr_sh = XW'(macc >>> NF);

	assign s_tready = (st_q == ST_IDLE);
	wire acc_in = s_tvalid && s_tready;

	always_comb begin
		opack = '0;
		for (int k = 0; k < 6; k++) opack[k*CW +: CW] = res_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			st_q    <= ST_IDLE;
			vout_q  <= 1'b0;
			wait_q  <= 1'b0;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (vout_q && m_tready) vout_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (acc_in) begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						st_q <= ST_DET;
						step_q <= '0;
						wait_q <= 1'b0;
					end else begin
						phase_q <= (phase_q == 2'd1) ? 2'd2 : 2'd1;
					end
				end
				ST_DET, ST_NUM, ST_CROSS: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mdone) begin
						wait_q <= 1'b0;
						if (step_q == 3'd0) begin
							step_q <= 3'd1;
						end else begin
							step_q <= 3'd0;
							if (st_q == ST_DET) begin
								st_q <= ST_NUM; idx_q <= '0;
							end else if (st_q == ST_NUM) begin
								if (idx_q == 3'd5) begin
									idx_q <= '0;
									st_q <= (det_q == '0) ? ST_OUT : ST_DIV;
								end else idx_q <= idx_q + 3'd1;
							end else begin
								if (idx_q == 3'd2) begin
									idx_q <= '0; st_q <= ST_DOT;
								end else idx_q <= idx_q + 3'd1;
							end
						end
					end
				end
				ST_DIV: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (!dbusy) begin
						wait_q <= 1'b0;
						if (idx_q == 3'd5) begin
							idx_q <= '0; st_q <= ST_CROSS;
						end else idx_q <= idx_q + 3'd1;
					end
				end
				ST_DOT: begin
					// Three products accumulate in the shared unit.
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mdone) begin
						wait_q <= 1'b0;
						if (idx_q == 3'd2) begin
							idx_q <= '0; st_q <= ST_FLIP;
						end else idx_q <= idx_q + 3'd1;
					end
				end
				ST_FLIP: st_q <= ST_OUT;
				ST_OUT: if (!vout_q) begin
					vout_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (phase_q == 2'd2) begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= (CW+1)'(p1_q[k]) - (CW+1)'(p0_q[k]);
					e2_q[k] <= (CW+1)'(in_p[k]) - (CW+1)'(p0_q[k]);
				end
				for (int k = 0; k < 2; k++) begin
					d1_q[k] <= (CW+1)'(t1_q[k]) - (CW+1)'(t0_q[k]);
					d2_q[k] <= (CW+1)'(in_t[k]) - (CW+1)'(t0_q[k]);
				end
			end else if (phase_q == 2'd1) begin
				p1_q <= in_p; t1_q <= in_t;
			end else begin
				p0_q <= in_p; t0_q <= in_t; n0_q <= in_n;
			end
		end
		if (st_q == ST_DET && wait_q && mdone && step_q == 3'd1) det_q <= macc;
		if (st_q == ST_NUM && wait_q && mdone && step_q == 3'd1) num_q[idx_q] <= macc;
		if (st_q == ST_DIV && !wait_q) qneg_q <= qneg;
		if (st_q == ST_DIV && wait_q && !dbusy) res_q[idx_q] <= qsat;
		if (st_q == ST_CROSS && wait_q && mdone && step_q == 3'd1)
			cr_q[idx_q[1:0]] <= cr_sh;
		if (st_q == ST_DOT && wait_q && mdone && idx_q == 3'd2) dot_q <= DW'(macc);
		if (st_q == ST_NUM && idx_q == 3'd5 && wait_q && mdone && step_q == 3'd1)
			degen_q <= (det_q == '0);
		if (st_q == ST_FLIP && dot_q[DW-1]) begin
			for (int k = 0; k < 3; k++)
				res_q[k] <= (res_q[k] == SMIN) ? SMAX : CW'(-res_q[k]);
		end
		if (st_q == ST_OUT && !vout_q) begin
			odata_q <= degen_q ? '0 : opack;
			ouser_q <= degen_q;
		end
	end

	assign m_tvalid = vout_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;
endmodule

FILE: hw/rtl/ttb_mac.sv
// Shared signed multiply-accumulate unit. One product per cycle, the product
// is registered before it is added into the accumulator.
module ttb_mac import ttb_pkg::*; #(
	parameter int OP_W  = 34,
	parameter int ACC_W = 72
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mul_ctl_t                ctl,
	input  logic signed [OP_W-1:0]  a,
	input  logic signed [OP_W-1:0]  b,
	output logic signed [ACC_W-1:0] acc,
	output logic                    done
);
	logic signed [2*OP_W-1:0] prod_s1;
	logic [1:0]               op_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= ctl.start;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		op_s1   <= ctl.op;
		if (vld_s1) begin
			case (op_s1)
				MOP_SET: acc_q <= prod_ext;
				MOP_ADD: acc_q <= acc_q + prod_ext;
				MOP_SUB: acc_q <= acc_q - prod_ext;
				default: acc_q <= prod_ext;
			endcase
		end
	end

	assign acc = acc_q;
endmodule

FILE: hw/rtl/ttb_div.sv
// Restoring divider, one quotient bit per cycle, on magnitudes.
module ttb_div #(
	parameter int N_W = 88,
	parameter int D_W = 72
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [N_W-1:0] quo,
	output logic           busy
);
	localparam int CW = $clog2(N_W + 1);
	logic [N_W-1:0] n_q;
	logic [D_W:0]   r_q;
	logic [D_W-1:0] d_q;
	logic [CW-1:0]  cnt_q;
	logic [D_W:0]   r_sh;

	assign r_sh = {r_q[D_W-1:0], n_q[N_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(N_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			quo <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[N_W-2:0], 1'b0};
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				quo <= {quo[N_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				quo <= {quo[N_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0) || start;
endmodule
